// ===== rtl/qesc_pkg.sv =====
// ----------------------------------------------------------------------------
// qesc_pkg
// Shared types and constants for the quadrature edge saturating counter:
// phase codes, edge event codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package qesc_pkg;

    // default counter width
    localparam int COUNT_WIDTH_DEF = 16;

    // width of every configuration register and of the count output
    localparam int CFG_WIDTH = 16;
    localparam int CFG_IDX_WIDTH = 3;

    // register reset values
    localparam logic [CFG_WIDTH-1:0] MIN_COUNT_RST = CFG_WIDTH'(0);
    localparam logic [CFG_WIDTH-1:0] MAX_COUNT_RST = CFG_WIDTH'(500);
    localparam logic [CFG_WIDTH-1:0] UP_STEP_RST   = CFG_WIDTH'(1);
    localparam logic [CFG_WIDTH-1:0] DOWN_STEP_RST = CFG_WIDTH'(1);

    // register indexes
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_MIN_COUNT   = 3'd0,
        CFG_MAX_COUNT   = 3'd1,
        CFG_UP_STEP     = 3'd2,
        CFG_DOWN_STEP   = 3'd3,
        CFG_START_VALUE = 3'd4
    } cfg_index_t;

    // decoder phase, one-hot
    typedef enum logic [3:0] {
        PH_REST = 4'b0001,
        PH_ONE  = 4'b0010,
        PH_TWO  = 4'b0100,
        PH_THREE = 4'b1000
    } phase_t;

    // edge event: {channel_b, rising}
    typedef enum logic [1:0] {
        EV_FALL_A = 2'b00,
        EV_RISE_A = 2'b01,
        EV_FALL_B = 2'b10,
        EV_RISE_B = 2'b11
    } edge_ev_t;

endpackage

// ===== rtl/quadrature_edge_saturating_counter.sv =====
// ----------------------------------------------------------------------------
// quadrature_edge_saturating_counter
// Takes one encoder edge per request, steps a four-phase decode table and
// moves a saturating position counter on each completed detent cycle.
// ----------------------------------------------------------------------------
// Rate: one edge request is taken every clock cycle unless m_ready stalls the
// result. The phase table step and the saturating add or subtract are done in
// the cycle the request is taken, and the result is registered in a single
// output register; the input stays ready while that register is empty or
// being emptied in the same cycle, so throughput is one request per cycle.
// Configuration writes take effect at the clock edge they are presented and
// are meant to be issued only while no request is in flight.
module quadrature_edge_saturating_counter #(
    parameter int COUNT_WIDTH = qesc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [qesc_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [qesc_pkg::CFG_WIDTH-1:0]      cfg_wdata,
    // edge request channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_channel_b,
    input  logic                                s_rising,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [qesc_pkg::CFG_WIDTH-1:0]      m_count,
    output logic                                m_stepped_up,
    output logic                                m_stepped_down
);

    // arithmetic width: wide enough for both counter and register plus carry
    localparam int AW = ((COUNT_WIDTH > qesc_pkg::CFG_WIDTH) ?
                         COUNT_WIDTH : qesc_pkg::CFG_WIDTH) + 1;

    // configuration registers
    logic [qesc_pkg::CFG_WIDTH-1:0] min_count_reg, min_count_next;
    logic [qesc_pkg::CFG_WIDTH-1:0] max_count_reg, max_count_next;
    logic [qesc_pkg::CFG_WIDTH-1:0] up_step_reg, up_step_next;
    logic [qesc_pkg::CFG_WIDTH-1:0] down_step_reg, down_step_next;

    // decoder state
    qesc_pkg::phase_t               phase_reg, phase_next;
    logic                           cw_flag_reg, cw_flag_next;
    logic                           ccw_flag_reg, ccw_flag_next;
    logic [COUNT_WIDTH-1:0]         position_reg, position_next;

    // result register
    logic                           m_valid_reg, m_valid_next;
    logic [qesc_pkg::CFG_WIDTH-1:0] m_count_reg;
    logic                           m_up_reg;
    logic                           m_down_reg;

    logic                           accept;
    qesc_pkg::edge_ev_t             ev;
    logic                           up_hit;
    logic                           down_hit;
    logic [AW-1:0]                  pos_ext;
    logic [AW-1:0]                  min_ext;
    logic [AW-1:0]                  max_ext;
    logic [AW-1:0]                  up_ext;
    logic [AW-1:0]                  down_ext;
    logic [AW-1:0]                  wdata_ext;
    logic [AW-1:0]                  sum;
    logic [AW-1:0]                  diff;
    logic [AW-1:0]                  up_val;
    logic [AW-1:0]                  down_val;
    logic [AW-1:0]                  pos_after_ext;
    logic [COUNT_WIDTH-1:0]         pos_after;
    logic [AW-1:0]                  pos_after_wide;

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;
    assign ev      = qesc_pkg::edge_ev_t'({s_channel_b, s_rising});

    // common-width views of counter and registers
    assign pos_ext   = AW'(position_reg);
    assign min_ext   = AW'(min_count_reg);
    assign max_ext   = AW'(max_count_reg);
    assign up_ext    = AW'(up_step_reg);
    assign down_ext  = AW'(down_step_reg);
    assign wdata_ext = AW'(cfg_wdata);

    // saturating add and subtract
    assign sum  = pos_ext + up_ext;
    assign diff = pos_ext - min_ext;

    always_comb begin
        up_val = pos_ext;
        if (pos_ext < max_ext) begin
            up_val = (sum > max_ext) ? max_ext : sum;
        end
        down_val = pos_ext;
        if (pos_ext > min_ext) begin
            down_val = (down_ext >= diff) ? min_ext : (pos_ext - down_ext);
        end
    end

    // phase table step
    always_comb begin
        phase_next    = phase_reg;
        cw_flag_next  = cw_flag_reg;
        ccw_flag_next = ccw_flag_reg;
        up_hit        = 1'b0;
        down_hit      = 1'b0;
        unique case (phase_reg)
            qesc_pkg::PH_REST: begin
                unique case (ev)
                    qesc_pkg::EV_FALL_A: begin
                        phase_next    = qesc_pkg::PH_ONE;
                        cw_flag_next  = 1'b1;
                        ccw_flag_next = 1'b0;
                    end
                    qesc_pkg::EV_FALL_B: begin
                        phase_next    = qesc_pkg::PH_THREE;
                        cw_flag_next  = 1'b0;
                        ccw_flag_next = 1'b1;
                    end
                    default: begin
                        phase_next    = qesc_pkg::PH_REST;
                        cw_flag_next  = 1'b0;
                        ccw_flag_next = 1'b0;
                    end
                endcase
            end
            qesc_pkg::PH_ONE: begin
                unique case (ev)
                    qesc_pkg::EV_RISE_A: begin
                        down_hit      = ccw_flag_reg;
                        phase_next    = qesc_pkg::PH_REST;
                        cw_flag_next  = 1'b0;
                        ccw_flag_next = 1'b0;
                    end
                    qesc_pkg::EV_FALL_B: phase_next = qesc_pkg::PH_TWO;
                    default:             phase_next = qesc_pkg::PH_ONE;
                endcase
            end
            qesc_pkg::PH_TWO: begin
                unique case (ev)
                    qesc_pkg::EV_RISE_A: phase_next = qesc_pkg::PH_THREE;
                    qesc_pkg::EV_RISE_B: phase_next = qesc_pkg::PH_ONE;
                    default:             phase_next = qesc_pkg::PH_TWO;
                endcase
            end
            qesc_pkg::PH_THREE: begin
                unique case (ev)
                    qesc_pkg::EV_RISE_B: begin
                        up_hit        = cw_flag_reg;
                        phase_next    = qesc_pkg::PH_REST;
                        cw_flag_next  = 1'b0;
                        ccw_flag_next = 1'b0;
                    end
                    qesc_pkg::EV_FALL_A: phase_next = qesc_pkg::PH_TWO;
                    default:             phase_next = qesc_pkg::PH_THREE;
                endcase
            end
            default: begin
                phase_next    = qesc_pkg::PH_REST;
                cw_flag_next  = 1'b0;
                ccw_flag_next = 1'b0;
            end
        endcase
    end

    // counter value after this edge
    always_comb begin
        priority if (up_hit) begin
            pos_after_ext = up_val;
        end else if (down_hit) begin
            pos_after_ext = down_val;
        end else begin
            pos_after_ext = pos_ext;
        end
    end

    // stored counter width, and its zero-extended view for the count output
    assign pos_after      = pos_after_ext[COUNT_WIDTH-1:0];
    assign pos_after_wide = AW'(pos_after);

    // register writes and counter update
    always_comb begin
        min_count_next = min_count_reg;
        max_count_next = max_count_reg;
        up_step_next   = up_step_reg;
        down_step_next = down_step_reg;
        position_next  = position_reg;
        if (accept) begin
            position_next = pos_after;
        end
        if (cfg_wr_en) begin
            unique case (qesc_pkg::cfg_index_t'(cfg_index))
                qesc_pkg::CFG_MIN_COUNT: begin
                    min_count_next = cfg_wdata;
                    if (pos_ext < wdata_ext) begin
                        position_next = wdata_ext[COUNT_WIDTH-1:0];
                    end
                end
                qesc_pkg::CFG_MAX_COUNT: begin
                    max_count_next = cfg_wdata;
                    if (pos_ext > wdata_ext) begin
                        position_next = wdata_ext[COUNT_WIDTH-1:0];
                    end
                end
                qesc_pkg::CFG_UP_STEP:     up_step_next   = cfg_wdata;
                qesc_pkg::CFG_DOWN_STEP:   down_step_next = cfg_wdata;
                qesc_pkg::CFG_START_VALUE: position_next  = wdata_ext[COUNT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // result valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_count_reg <= qesc_pkg::MIN_COUNT_RST;
            max_count_reg <= qesc_pkg::MAX_COUNT_RST;
            up_step_reg   <= qesc_pkg::UP_STEP_RST;
            down_step_reg <= qesc_pkg::DOWN_STEP_RST;
            phase_reg     <= qesc_pkg::PH_REST;
            cw_flag_reg   <= 1'b0;
            ccw_flag_reg  <= 1'b0;
            position_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            min_count_reg <= min_count_next;
            max_count_reg <= max_count_next;
            up_step_reg   <= up_step_next;
            down_step_reg <= down_step_next;
            position_reg  <= position_next;
            m_valid_reg   <= m_valid_next;
            if (accept) begin
                phase_reg    <= phase_next;
                cw_flag_reg  <= cw_flag_next;
                ccw_flag_reg <= ccw_flag_next;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_count_reg <= pos_after_wide[qesc_pkg::CFG_WIDTH-1:0];
            m_up_reg    <= up_hit;
            m_down_reg  <= down_hit;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_count        = m_count_reg;
    assign m_stepped_up   = m_up_reg;
    assign m_stepped_down = m_down_reg;

    // a completed cycle counts in one direction only
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_up_reg && m_down_reg))
        else $error("result flags both up and down");

    // a completed cycle always returns the decoder to rest
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (up_hit || down_hit)) |=> (phase_reg == qesc_pkg::PH_REST))
        else $error("decoder not at rest after a completed cycle");

    // an upward count that moved never passes the upper bound
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && up_hit && !cfg_wr_en) |=>
            ((position_reg == $past(position_reg)) ||
             (AW'(position_reg) <= AW'(max_count_reg))))
        else $error("upward count passed max_count");

    // flags are never both set
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(cw_flag_reg && ccw_flag_reg))
        else $error("both direction flags set");

endmodule
